/* hdl/wpsc_pkg.sv */
// Shared types and constants for the wheel PID speed controller.
`timescale 1ns / 1ps
`default_nettype none

package wpsc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICK      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX = 3'd6;

  localparam int ERR_W  = 33;  // Q24.8 error
  localparam int DIF_W  = 34;  // error difference
  localparam int INT_W  = 26;  // Q17.8 integral
  localparam int OUT_W  = 18;  // Q9.8 stored output
  localparam int MA_W   = 34;
  localparam int MB_W   = 17;
  localparam int PROD_W = 51;
  localparam int ACC_W  = 62;  // Q.24 term sum

  localparam int DIV_W          = 60;
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_ITER       = DIV_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = 4;

  localparam logic signed [OUT_W-1:0] OUT_RESET = 18'sh08000;
  localparam logic signed [OUT_W-1:0] OUT_MAX   = 18'sh1FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN   = 18'sh20000;
  localparam logic signed [ACC_W-1:0] MIDPOINT  = 62'sh0_8000_0000;
  localparam logic [7:0]              SPEED_FLOOR = 8'd128;

  localparam logic [1:0] MUL_ERR_DT = 2'd0;
  localparam logic [1:0] MUL_ERR_P  = 2'd1;
  localparam logic [1:0] MUL_INT_I  = 2'd2;
  localparam logic [1:0] MUL_DIF_D  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       prep;
    logic [1:0] mul_sel;
    logic       integ_en;
    logic       acc_p;
    logic       acc_i;
    logic       div_load;
    logic       div_step;
    logic       acc_d;
    logic       slew_en;
    logic       commit;
  } wpsc_cmd_t;

  typedef struct packed {
    logic div_last;
  } wpsc_sts_t;

endpackage

`default_nettype wire

/* hdl/wpsc_datapath.sv */
// Datapath: config registers, per-wheel state, shared multiplier, divider, clamps.
`timescale 1ns / 1ps
`default_nettype none

module wpsc_datapath #(
  parameter int WHEELS = 2
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire  [wpsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [wpsc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                 wheel,
  input  wire                                 restart,
  input  wire  signed [31:0]                  target_pos,
  input  wire  signed [31:0]                  measured_pos,
  input  wpsc_pkg::wpsc_cmd_t                 cmd,
  output wpsc_pkg::wpsc_sts_t                 sts,
  output logic [7:0]                          drive_code
);

  localparam int WW = (WHEELS > 1) ? $clog2(WHEELS) : 1;

  logic [15:0] gain_p, gain_i, gain_d, tick_period_us, integral_limit;
  logic [7:0]  slew_step, speed_max;

  logic [WW-1:0] widx;
  logic          rst_hist;
  logic signed [wpsc_pkg::ERR_W-1:0]  err;
  logic signed [wpsc_pkg::DIF_W-1:0]  ediff;
  logic signed [wpsc_pkg::INT_W-1:0]  integ;
  logic signed [wpsc_pkg::PROD_W-1:0] prod;
  logic signed [wpsc_pkg::ACC_W-1:0]  acc;
  logic signed [wpsc_pkg::OUT_W-1:0]  res;

  logic signed [wpsc_pkg::ERR_W-1:0] last_error   [WHEELS];
  logic signed [wpsc_pkg::INT_W-1:0] integral_sum [WHEELS];
  logic signed [wpsc_pkg::OUT_W-1:0] last_output  [WHEELS];

  logic                              dsign;
  logic [wpsc_pkg::DIV_W-1:0]        div_q, div_q_next;
  logic [15:0]                       div_rem, div_rem_next;
  logic [wpsc_pkg::DIV_CNT_W-1:0]    div_cnt;

  logic [15:0] dt;
  logic signed [wpsc_pkg::ERR_W-1:0] le_rd;
  logic signed [wpsc_pkg::INT_W-1:0] is_rd;
  logic signed [wpsc_pkg::OUT_W-1:0] prev;

  assign dt    = (tick_period_us == 16'd0) ? 16'd1 : tick_period_us;
  assign le_rd = rst_hist ? '0 : last_error[widx];
  assign is_rd = rst_hist ? '0 : integral_sum[widx];
  assign prev  = last_output[widx];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= 16'd102;
      gain_i         <= 16'd26;
      gain_d         <= 16'd77;
      tick_period_us <= 16'd5000;
      integral_limit <= 16'd40;
      slew_step      <= 8'd1;
      speed_max      <= 8'd180;
    end else if (cfg_we) begin
      case (cfg_index)
        wpsc_pkg::REG_GAIN_P:    gain_p         <= cfg_data;
        wpsc_pkg::REG_GAIN_I:    gain_i         <= cfg_data;
        wpsc_pkg::REG_GAIN_D:    gain_d         <= cfg_data;
        wpsc_pkg::REG_TICK:      tick_period_us <= cfg_data;
        wpsc_pkg::REG_INT_LIMIT: integral_limit <= cfg_data;
        wpsc_pkg::REG_SLEW:      slew_step      <= cfg_data[7:0];
        wpsc_pkg::REG_SPEED_MAX: speed_max      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // item capture and error
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      widx     <= (WHEELS > 1) ? WW'(wheel) : WW'(1'b0);
      rst_hist <= restart;
      err      <= {target_pos[31], target_pos} - {measured_pos[31], measured_pos};
    end
    if (cmd.prep) begin
      ediff <= wpsc_pkg::DIF_W'(err) - wpsc_pkg::DIF_W'(le_rd);
    end
  end

  // shared multiplier
  logic signed [wpsc_pkg::MA_W-1:0] ma;
  logic signed [wpsc_pkg::MB_W-1:0] mb;

  always_comb begin
    case (cmd.mul_sel)
      wpsc_pkg::MUL_ERR_P: begin
        ma = wpsc_pkg::MA_W'(err);
        mb = {1'b0, gain_p};
      end
      wpsc_pkg::MUL_INT_I: begin
        ma = wpsc_pkg::MA_W'(integ);
        mb = {1'b0, gain_i};
      end
      wpsc_pkg::MUL_DIF_D: begin
        ma = ediff;
        mb = {1'b0, gain_d};
      end
      default: begin
        ma = wpsc_pkg::MA_W'(err);
        mb = {1'b0, dt};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= wpsc_pkg::PROD_W'(ma) * wpsc_pkg::PROD_W'(mb);
  end

  // integral with anti-windup clamp
  logic signed [wpsc_pkg::PROD_W:0] iraw, lim_pos, lim_neg;

  assign iraw    = (wpsc_pkg::PROD_W+1)'(is_rd) + (wpsc_pkg::PROD_W+1)'(prod);
  assign lim_pos = (wpsc_pkg::PROD_W+1)'({integral_limit, 8'd0});
  assign lim_neg = -lim_pos;

  always_ff @(posedge clk) begin
    if (cmd.integ_en) begin
      if (iraw > lim_pos)
        integ <= wpsc_pkg::INT_W'(lim_pos);
      else if (iraw < lim_neg)
        integ <= wpsc_pkg::INT_W'(lim_neg);
      else
        integ <= wpsc_pkg::INT_W'(iraw);
    end
  end

  // derivative divider, radix 16 restoring on magnitudes
  logic [wpsc_pkg::PROD_W-1:0]       dmag;
  logic signed [wpsc_pkg::ACC_W-1:0] dq_ext;

  assign dmag   = prod[wpsc_pkg::PROD_W-1] ? wpsc_pkg::PROD_W'(-prod)
                                           : wpsc_pkg::PROD_W'(prod);
  assign dq_ext = signed'(wpsc_pkg::ACC_W'(div_q));
  assign sts.div_last = (div_cnt == wpsc_pkg::DIV_CNT_W'(wpsc_pkg::DIV_ITER - 1));

  always_comb begin
    logic [16:0] r;
    div_q_next   = div_q;
    div_rem_next = div_rem;
    for (int i = 0; i < wpsc_pkg::DIV_RADIX_BITS; i++) begin
      r          = {div_rem_next, div_q_next[wpsc_pkg::DIV_W-1]};
      div_q_next = {div_q_next[wpsc_pkg::DIV_W-2:0], 1'b0};
      if (r >= {1'b0, dt}) begin
        r             = r - {1'b0, dt};
        div_q_next[0] = 1'b1;
      end
      div_rem_next = r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dsign   <= prod[wpsc_pkg::PROD_W-1];
      div_q   <= wpsc_pkg::DIV_W'(dmag) << 8;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_q   <= div_q_next;
      div_rem <= div_rem_next;
      div_cnt <= div_cnt + wpsc_pkg::DIV_CNT_W'(1);
    end
  end

  // term accumulator, Q.24
  always_ff @(posedge clk) begin
    if (cmd.acc_p)
      acc <= (wpsc_pkg::ACC_W'(prod) <<< 8) + wpsc_pkg::MIDPOINT;
    else if (cmd.acc_i)
      acc <= acc + (wpsc_pkg::ACC_W'(prod) <<< 8);
    else if (cmd.acc_d)
      acc <= acc + (dsign ? -dq_ext : dq_ext);
  end

  // slew limit and output saturation
  logic signed [19:0] slew_s, up, dn, res_w;
  logic signed [wpsc_pkg::ACC_W-1:0] up_b, dn_b;

  assign slew_s = signed'({4'd0, slew_step, 8'd0});
  assign up     = 20'(prev) + slew_s;
  assign dn     = 20'(prev) - slew_s;
  assign up_b   = wpsc_pkg::ACC_W'(up) <<< 16;
  assign dn_b   = wpsc_pkg::ACC_W'(dn) <<< 16;

  always_comb begin
    if (acc > up_b)
      res_w = up;
    else if (acc < dn_b)
      res_w = dn;
    else
      res_w = 20'(acc >>> 16);
  end

  always_ff @(posedge clk) begin
    if (cmd.slew_en) begin
      if (res_w > 20'(wpsc_pkg::OUT_MAX))
        res <= wpsc_pkg::OUT_MAX;
      else if (res_w < 20'(wpsc_pkg::OUT_MIN))
        res <= wpsc_pkg::OUT_MIN;
      else
        res <= wpsc_pkg::OUT_W'(res_w);
    end
  end

  // drive clamp
  logic [7:0] sm, lo, drv;
  logic signed [wpsc_pkg::OUT_W-1:0] lo_b, hi_b;

  assign sm   = (speed_max < wpsc_pkg::SPEED_FLOOR) ? wpsc_pkg::SPEED_FLOOR : speed_max;
  assign lo   = 8'(9'd256 - {1'b0, sm});
  assign lo_b = signed'({2'b00, lo, 8'd0});
  assign hi_b = signed'({2'b00, sm, 8'd0});

  always_comb begin
    if (res < lo_b)
      drv = lo;
    else if (res > hi_b)
      drv = sm;
    else
      drv = res[15:8];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      drive_code <= drv;
    end
  end

  // per-wheel history
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WHEELS; i++) begin
        last_error[i]   <= '0;
        integral_sum[i] <= '0;
        last_output[i]  <= wpsc_pkg::OUT_RESET;
      end
    end else if (cmd.commit) begin
      last_error[widx]   <= err;
      integral_sum[widx] <= integ;
      last_output[widx]  <= res;
    end
  end

endmodule

`default_nettype wire

/* hdl/wpsc_controller.sv */
// Sequencer: steps the datapath through one control tick and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none

module wpsc_controller (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  input  wpsc_pkg::wpsc_sts_t  sts,
  output wpsc_pkg::wpsc_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL_ID = 4'd1;
  localparam logic [3:0] S_INTEG  = 4'd2;
  localparam logic [3:0] S_ACC_P  = 4'd3;
  localparam logic [3:0] S_ACC_I  = 4'd4;
  localparam logic [3:0] S_DIV_LD = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_ACC_D  = 4'd7;
  localparam logic [3:0] S_SLEW   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state, state_next;
  logic       in_fire, out_free;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_fire) state_next = S_MUL_ID;
      S_MUL_ID: state_next = S_INTEG;
      S_INTEG:  state_next = S_ACC_P;
      S_ACC_P:  state_next = S_ACC_I;
      S_ACC_I:  state_next = S_DIV_LD;
      S_DIV_LD: state_next = S_DIV;
      S_DIV:    if (sts.div_last) state_next = S_ACC_D;
      S_ACC_D:  state_next = S_SLEW;
      S_SLEW:   state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free)
        out_valid <= 1'b1;
      else if (!out_stall)
        out_valid <= 1'b0;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = wpsc_pkg::MUL_ERR_DT;
    cmd.load    = in_fire;
    case (state)
      S_MUL_ID: cmd.prep = 1'b1;
      S_INTEG: begin
        cmd.integ_en = 1'b1;
        cmd.mul_sel  = wpsc_pkg::MUL_ERR_P;
      end
      S_ACC_P: begin
        cmd.acc_p   = 1'b1;
        cmd.mul_sel = wpsc_pkg::MUL_INT_I;
      end
      S_ACC_I: begin
        cmd.acc_i   = 1'b1;
        cmd.mul_sel = wpsc_pkg::MUL_DIF_D;
      end
      S_DIV_LD: cmd.div_load = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_ACC_D:  cmd.acc_d    = 1'b1;
      S_SLEW:   cmd.slew_en  = 1'b1;
      S_DONE:   cmd.commit   = out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/wheel_pid_speed_controller_top.sv */
// Top level of the two-wheel PID speed controller.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall    wheel, restart, target_pos, measured_pos
//   out      source     out_valid / out_stall  drive_code
//   cfg      sink       cfg_we                 cfg_index, cfg_data
//
// Each item is stepped by the sequencer around one shared 34x17 multiplier and through
// the radix-16 divider that forms the derivative term.
// The result reaches a one-deep output register; the next item is taken while it waits.
// If that register is still full at the end of an item, the sequencer holds until it drains.
// Synchronous reset loads the default gains and resets each wheel's history.
`timescale 1ns / 1ps
`default_nettype none

module wheel_pid_speed_controller_top #(
  parameter int WHEELS = 2
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire  [wpsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [wpsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               wheel,
  input  wire                               restart,
  input  wire  signed [31:0]                target_pos,
  input  wire  signed [31:0]                measured_pos,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [7:0]                        drive_code
);

  wpsc_pkg::wpsc_cmd_t cmd;
  wpsc_pkg::wpsc_sts_t sts;

  wpsc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  wpsc_datapath #(
    .WHEELS (WHEELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .wheel        (wheel),
    .restart      (restart),
    .target_pos   (target_pos),
    .measured_pos (measured_pos),
    .cmd          (cmd),
    .sts          (sts),
    .drive_code   (drive_code)
  );

endmodule

`default_nettype wire

/* hdl/wpsc_checker.sv */
// Port-level checks for the PID speed controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wpsc_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire [7:0] drive_code
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive_code))
    else $error("stalled result changed or dropped");

  // a transfer in keeps the block busy on the next cycle
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled right after a transfer");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // the lower drive clamp is never below one
  a_drive_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive_code != 8'd0)
    else $error("drive code below clamp");

endmodule

bind wheel_pid_speed_controller_top wpsc_checker u_wpsc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .drive_code (drive_code)
);

`default_nettype wire

/* test/wheel_pid_speed_controller_top_tb.sv */
// Self-checking testbench for the two-wheel PID speed controller: random traffic, built-in predictor.
`timescale 1ns / 1ps

module wheel_pid_speed_controller_top_tb;

  localparam int WHEELS = 2;
  localparam logic [wpsc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint DRIVE_Q8_MAX = 131071;
  localparam longint DRIVE_Q8_MIN = -131072;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic        wheel;
    logic        restart;
    logic [31:0] target_pos;
    logic [31:0] measured_pos;
  } speed_tick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [wpsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wpsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic wheel = 1'b0;
  logic restart = 1'b0;
  logic signed [31:0] target_pos = '0;
  logic signed [31:0] measured_pos = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] drive_code;

  wheel_pid_speed_controller_top #(.WHEELS(WHEELS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .wheel(wheel),
    .restart(restart),
    .target_pos(target_pos),
    .measured_pos(measured_pos),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .drive_code(drive_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers and per-wheel history
  logic [15:0] k_p, k_i, k_d, dt_us, int_lim;
  logic [7:0]  slew_lim, spd_max;
  longint      err_hist [WHEELS];
  longint      integ_acc [WHEELS];
  longint      out_hist [WHEELS];

  speed_tick_t tick_q [$];
  logic [7:0]  expected_drive [$];
  speed_tick_t cur;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left = 0;

  task automatic clear_model();
    k_p = 16'd102; k_i = 16'd26; k_d = 16'd77;
    dt_us = 16'd5000; int_lim = 16'd40;
    slew_lim = 8'd1; spd_max = 8'd180;
    for (int w = 0; w < WHEELS; w++) begin
      err_hist[w] = 0;
      integ_acc[w] = 0;
      out_hist[w] = 128 * 256;
    end
  endtask

  function automatic logic [7:0] predict_drive(speed_tick_t t);
    int     w;
    longint dt, lim, sm, tgt, msr, err, integ, gp, gi, gd;
    longint sum, prev, slew, res, code;
    w = int'(t.wheel) % WHEELS;
    dt = longint'(dt_us);
    if (dt == 0) dt = 1;
    lim = longint'(int_lim);
    lim = lim * 256;
    sm = longint'(spd_max);
    if (sm < 128) sm = 128;
    gp = longint'(k_p);
    gi = longint'(k_i);
    gd = longint'(k_d);
    if (t.restart) begin
      err_hist[w] = 0;
      integ_acc[w] = 0;
    end
    tgt = longint'($signed(t.target_pos));
    msr = longint'($signed(t.measured_pos));
    err = tgt - msr;
    integ = integ_acc[w] + err * dt;
    if (integ > lim) integ = lim;
    else if (integ < -lim) integ = -lim;
    integ_acc[w] = integ;
    sum = gp * err * 256 + gi * integ * 256 + (gd * (err - err_hist[w]) * 256) / dt
          + (64'sd128 <<< 24);
    err_hist[w] = err;
    prev = out_hist[w];
    slew = longint'(slew_lim);
    slew = slew * 256;
    if (sum > (prev + slew) * 65536) res = prev + slew;
    else if (sum < (prev - slew) * 65536) res = prev - slew;
    else res = sum >>> 16;
    if (res > DRIVE_Q8_MAX) res = DRIVE_Q8_MAX;
    else if (res < DRIVE_Q8_MIN) res = DRIVE_Q8_MIN;
    out_hist[w] = res;
    if (res < (256 - sm) * 256) code = 256 - sm;
    else if (res > sm * 256) code = sm;
    else code = res >>> 8;
    return code[7:0];
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_drive.push_back(predict_drive(cur));
      if (!in_valid || !in_stall) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur = tick_q.pop_front();
          in_valid <= 1'b1;
          wheel <= cur.wheel;
          restart <= cur.restart;
          target_pos <= cur.target_pos;
          measured_pos <= cur.measured_pos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_drive.size() == 0) begin
          $error("drive_code: expected none, got %0d", drive_code);
          errors++;
        end else if (drive_code !== expected_drive[0]) begin
          $error("drive_code: expected %0d, got %0d", expected_drive[0], drive_code);
          errors++;
        end
        if (expected_drive.size() != 0) void'(expected_drive.pop_front());
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic void queue_tick(logic w, logic r, logic [31:0] t, logic [31:0] m);
    tick_q.push_back({w, r, t, m});
  endfunction

  task automatic set_reg(logic [wpsc_pkg::CFG_IDX_W-1:0] idx,
                         logic [wpsc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      wpsc_pkg::REG_GAIN_P:    k_p = val;
      wpsc_pkg::REG_GAIN_I:    k_i = val;
      wpsc_pkg::REG_GAIN_D:    k_d = val;
      wpsc_pkg::REG_TICK:      dt_us = val;
      wpsc_pkg::REG_INT_LIMIT: int_lim = val;
      wpsc_pkg::REG_SLEW:      slew_lim = val[7:0];
      wpsc_pkg::REG_SPEED_MAX: spd_max = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd, logic [15:0] tk,
                           logic [15:0] lim, logic [15:0] sl, logic [15:0] sm);
    set_reg(wpsc_pkg::REG_GAIN_P, gp);
    set_reg(wpsc_pkg::REG_GAIN_I, gi);
    set_reg(wpsc_pkg::REG_GAIN_D, gd);
    set_reg(wpsc_pkg::REG_TICK, tk);
    set_reg(wpsc_pkg::REG_INT_LIMIT, lim);
    set_reg(wpsc_pkg::REG_SLEW, sl);
    set_reg(wpsc_pkg::REG_SPEED_MAX, sm);
    set_reg(REG_UNUSED, 16'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int near_pos();
    return int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
  endfunction

  // mostly restart-led runs converging on a setpoint, some raw noise
  task automatic queue_random(int count);
    int n, len, tgt, msr;
    logic w;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 75) begin
        w = 1'($urandom_range(1));
        len = $urandom_range(4, 16);
        tgt = near_pos();
        msr = near_pos();
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 15) begin
            queue_tick(!w, 1'b0, near_pos(), near_pos());
          end else begin
            queue_tick(w, i == 0, tgt, msr);
            msr = msr + (tgt - msr) / int'($urandom_range(2, 6))
                  + int'($urandom_range(0, 512)) - 256;
          end
          n++;
        end
      end else begin
        queue_tick(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, $urandom);
        n++;
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_valid || expected_drive.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    clear_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 35;
    recv_idle_pct = 77;
    queue_tick(1'b0, 1'b1, 32'h0, 32'h0);
    queue_tick(1'b0, 1'b0, 32'h0000_6400, 32'h0);
    queue_tick(1'b0, 1'b0, 32'h0000_6400, 32'h0000_1000);
    queue_tick(1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_tick(1'b1, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_tick(1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_tick(1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_tick(1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0);
    queue_tick(1'b0, 1'b0, 32'h0, 32'hFFFF_FFFF);
    queue_tick(1'b0, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_tick(1'b1, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_tick(1'b0, 1'b0, 32'h1234_5600, 32'h1234_5600);
    for (int i = 0; i < 8; i++) queue_tick(i[0], 1'b0, 32'h7FFF_FFFF, 32'h0);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: load_regs(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h00FF, 16'h0);
        2: load_regs(16'd102, 16'd26, 16'd77, 16'd1, 16'd40, 16'h0, 16'd127);
        default:
          load_regs(16'($urandom_range(1) ? $urandom_range(1023) : $urandom_range(65535)),
                    16'($urandom_range(1) ? $urandom_range(255) : $urandom_range(65535)),
                    16'($urandom_range(1) ? $urandom_range(1023) : $urandom_range(65535)),
                    16'($urandom_range(3) != 0 ? $urandom_range(1, 10000)
                                               : $urandom_range(65535)),
                    16'($urandom_range(65535)),
                    16'($urandom_range(1) ? $urandom_range(16) : $urandom_range(65535)),
                    16'($urandom_range(255)));
      endcase
      @(negedge clk);
      send_idle_pct = (p < 3) ? 35 : (p < 6) ? 77 : 0;
      recv_idle_pct = (p < 3) ? 77 : (p < 6) ? 35 : 0;
      if (p == 6) hold_left = HOLD_CYCLES;
      queue_random(125);
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
